### design/assert_macros.svh
// Assertion macros for the RTL of the segment serializer.
// No dependencies; included by the top level, the only module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/stdss_pkg.sv
// Package of the signed three-digit segment serializer: segment codes.
// No dependencies; imported by the top level.
`default_nettype none

package stdss_pkg;

    typedef logic [7:0] t_seg;

    localparam t_seg SEG_BLANK = 8'h01;
    localparam t_seg SEG_MINUS = 8'h02;

    localparam t_seg SEG_DIGIT [10] = '{
        8'hFD, 8'h61, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE1, 8'hFF, 8'hF7
    };

endpackage

`default_nettype wire

### design/signed_three_digit_segment_serializer.sv
// Signed three-digit seven-segment serializer, top level.
// Depends on stdss_pkg and assert_macros.svh.
//
// Use: a signed 8-bit value arrives as one word on the slave stream
// (i_s_tdata). It is shown as its decimal magnitude on three seven-segment
// digits with leading blanking and a minus segment for negative values.
// For every value the master stream delivers one frame of FRAME_BITS
// words, one serial bit per word in o_m_tdata[0]: a 1 start bit, the
// hundreds, tens and units patterns MSB first, then zero bits. o_m_tlast
// marks the last word of the frame.
// The first word of a frame is offered once its value has passed the input
// register and been loaded into the shifter, when the shifter is free. The
// single output shift register moves one bit per accepted word; a waiting
// value is loaded as the last word is taken, so frames follow without a gap.
// A new value is taken into the input register while the previous frame is
// still shifting, so one value waits ahead of the shifter.
// When the receiver stalls (i_m_tready low), the current bit holds and the
// input side stops once its register is full.
// Reset (synchronous, active low) empties both stages; no frame is pending.
`default_nettype none
`include "assert_macros.svh"

module signed_three_digit_segment_serializer #(
    parameter int FRAME_BITS = 36
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,  // [7:0] value (signed)
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,  // [0] serial_bit, [7:1] zero
    output logic            o_m_tlast   // frame_end
);
    import stdss_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BITS);
    localparam int PAD   = FRAME_BITS - 25;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BITS - 1);

    logic                  r_in_valid;
    logic [7:0]            r_in_value;
    logic                  r_busy;
    logic [CNT_W-1:0]      r_count;
    logic [FRAME_BITS-1:0] r_shift;

    logic                  out_fire;
    logic                  last_fire;
    logic                  load;
    logic                  neg;
    logic [7:0]            mag;
    logic                  hund;
    logic [6:0]            rem;
    logic [14:0]           prod;
    logic [3:0]            tens;
    logic [6:0]            tens_x10;
    logic [3:0]            units;
    t_seg                  p0;
    t_seg                  p1;
    t_seg                  p2;
    logic [24:0]           pat;
    logic [FRAME_BITS-1:0] n_shift;

    assign out_fire  = r_busy && i_m_tready;
    assign last_fire = out_fire && (r_count == LAST_CNT);
    assign load      = r_in_valid && (!r_busy || last_fire);
    assign o_s_tready = !r_in_valid || load;

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {7'd0, r_shift[FRAME_BITS-1]};
    assign o_m_tlast  = r_busy && (r_count == LAST_CNT);

    always_comb begin
        neg  = r_in_value[7];
        mag  = neg ? (8'd0 - r_in_value) : r_in_value;
        hund = (mag >= 8'd100);
        rem  = hund ? 7'(mag - 8'd100) : mag[6:0];
        prod = 15'(rem) * 15'd205;
        tens = prod[14:11];
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        units = 4'(rem - tens_x10);

        p2 = SEG_DIGIT[units];
        p1 = (tens == 4'd0 && !hund) ? SEG_BLANK : SEG_DIGIT[tens];
        p0 = hund ? SEG_DIGIT[1] : SEG_BLANK;
        if (neg) begin
            if (mag < 8'd10) begin
                p1 = p1 | SEG_MINUS;
            end else begin
                p0 = p0 | SEG_MINUS;
            end
        end
        p0 = p0 ^ SEG_BLANK;
        p1 = p1 ^ SEG_BLANK;
        p2 = p2 ^ SEG_BLANK;

        pat     = {1'b1, p0, p1, p2};
        n_shift = FRAME_BITS'(pat) << PAD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_value <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (load) begin
            r_busy  <= 1'b1;
            r_count <= '0;
        end else if (out_fire) begin
            r_busy  <= !last_fire;
            r_count <= last_fire ? '0 : r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else if (load) begin
            r_shift <= n_shift;
        end else if (out_fire) begin
            r_shift <= r_shift << 1;
        end
    end

    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= LAST_CNT, "count past frame end")
    `ASSERT_CLK(a_start_bit, i_clk, i_rst_n, load |=> (o_m_tdata[0] && r_count == '0), "bad start")
    `ASSERT_CLK(a_pending_starts, i_clk, i_rst_n, (r_in_valid && !r_busy) |=> r_busy, "no load")
    `ASSERT_CLK(a_frame_done, i_clk, i_rst_n, (last_fire && !r_in_valid) |=> !o_m_tvalid, "late")
    `ASSERT_ALWAYS(a_last_valid, i_clk, o_m_tlast |-> o_m_tvalid, "tlast without tvalid")

endmodule

`default_nettype wire

### sim/stdss_frame_check.sv
// Frame checker for the signed three-digit segment serializer bench.
// Watches both streams, predicts the FRAME_BITS-bit frame of every value and
// compares each serial word; depends on nothing but its own ports.
module stdss_frame_check #(
    parameter int FRAME_BITS = 36
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,  // [7:0] value (signed)
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,  // [0] serial_bit, [7:1] zero
    input  logic       i_m_tlast,  // frame_end
    output int         o_fail_count,
    output int         o_pending_words,
    output int         o_words_checked
);

    localparam logic [7:0] BLANK_SEGMENT = 8'h01;
    localparam logic [7:0] MINUS_SEGMENT = 8'h02;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_serial_word;

    t_serial_word expected_words [$];

    int fail_count    = 0;
    int words_checked = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_words = expected_words.size();
    assign o_words_checked = words_checked;

    function automatic logic [7:0] digit_segments(input int digit);
        case (digit)
            0: return 8'hFD;
            1: return 8'h61;
            2: return 8'hDB;
            3: return 8'hF3;
            4: return 8'h67;
            5: return 8'hB7;
            6: return 8'hBF;
            7: return 8'hE1;
            8: return 8'hFF;
            default: return 8'hF7;
        endcase
    endfunction

    // Magnitude of a negative value is 256 minus the raw byte, so -128 shows as minus, 1, 2, 8.
    function automatic logic [FRAME_BITS-1:0] build_segment_frame(input logic [7:0] raw);
        logic                  negative;
        int                    magnitude;
        int                    units;
        int                    tens;
        int                    hundreds;
        logic [7:0]            hund_pat;
        logic [7:0]            tens_pat;
        logic [7:0]            unit_pat;
        logic [FRAME_BITS-1:0] frame;
        negative  = raw[7];
        magnitude = negative ? int'(9'h100 - raw) : int'(raw);
        units     = magnitude % 10;
        tens      = (magnitude / 10) % 10;
        hundreds  = (magnitude / 100) % 10;
        unit_pat  = digit_segments(units);
        tens_pat  = (tens == 0 && magnitude < 100) ? BLANK_SEGMENT : digit_segments(tens);
        hund_pat  = (hundreds == 0) ? BLANK_SEGMENT : digit_segments(hundreds);
        if (negative) begin
            if (magnitude < 10) begin
                tens_pat = tens_pat | MINUS_SEGMENT;
            end else begin
                hund_pat = hund_pat | MINUS_SEGMENT;
            end
        end
        frame = '0;
        frame[FRAME_BITS-1]        = 1'b1;
        frame[FRAME_BITS-2 -: 8]   = hund_pat ^ 8'h01;
        frame[FRAME_BITS-10 -: 8]  = tens_pat ^ 8'h01;
        frame[FRAME_BITS-18 -: 8]  = unit_pat ^ 8'h01;
        return frame;
    endfunction

    always @(posedge i_clk) begin
        logic [FRAME_BITS-1:0] frame;
        t_serial_word          want;
        t_serial_word          got;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got.data = i_m_tdata;
                got.last = i_m_tlast;
                if (expected_words.size() == 0) begin
                    fail_count <= fail_count + 1;
                    $display("%0t: unexpected word: expected none, got data %h last %b",
                             $time, got.data, got.last);
                end else begin
                    want = expected_words.pop_front();
                    words_checked <= words_checked + 1;
                    if (got.data !== want.data || got.last !== want.last) begin
                        fail_count <= fail_count + 1;
                        $display("%0t: word mismatch: expected data %h last %b, got data %h last %b",
                                 $time, want.data, want.last, got.data, got.last);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                frame = build_segment_frame(i_s_tdata);
                for (int i = FRAME_BITS - 1; i >= 0; i--) begin
                    want.data = {7'b0, frame[i]};
                    want.last = (i == 0);
                    expected_words.push_back(want);
                end
            end
        end
    end

endmodule

### sim/tb_signed_three_digit_segment_serializer.sv
// Top of the signed three-digit segment serializer bench: clock, reset,
// bursty value stimulus and a stalling frame receiver. Depends on the
// serializer RTL and on stdss_frame_check, which does the comparing.
module tb_signed_three_digit_segment_serializer;

    localparam int FRAME_BITS   = 36;
    localparam int DIRECTED_NUM = 22;
    localparam int RANDOM_NUM   = 98;
    localparam int TOTAL_NUM    = DIRECTED_NUM + RANDOM_NUM;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_QUARTER,
        READY_TOGGLE
    } t_ready_mode;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       s_tvalid   = 1'b0;
    logic [7:0] s_tdata    = 8'h00;
    logic       m_tready   = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int fail_count;
    int pending_words;
    int words_checked;
    int cycle_count = 0;

    t_ready_mode ready_mode   = READY_ALWAYS;
    int          ready_period = 0;

    int directed_values [DIRECTED_NUM] = '{
        0, 1, 9, -1, -9, 10, -10, 11, -11, 99, -99,
        100, -100, 101, 110, 127, -127, -128, -120, 55, -55, 105
    };

    always #4 i_clk = ~i_clk;

    signed_three_digit_segment_serializer #(
        .FRAME_BITS(FRAME_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast)
    );

    stdss_frame_check #(
        .FRAME_BITS(FRAME_BITS)
    ) frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending_words(pending_words),
        .o_words_checked(words_checked)
    );

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge i_clk) begin
        if (ready_period == 0) begin
            ready_mode   <= t_ready_mode'($urandom_range(0, 3));
            ready_period <= $urandom_range(20, 200);
        end else begin
            ready_period <= ready_period - 1;
        end
        case (ready_mode)
            READY_ALWAYS:  m_tready <= 1'b1;
            READY_HALF:    m_tready <= $urandom_range(0, 1);
            READY_QUARTER: m_tready <= ($urandom_range(0, 3) == 0);
            default:       m_tready <= ~m_tready;
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("signed_three_digit_segment_serializer regression: fail");
            $finish;
        end
    end

    task automatic send_value(input logic [7:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        int burst;
        int gap;
        sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (sent < TOTAL_NUM) begin
            burst = $urandom_range(1, 10);
            for (int k = 0; k < burst && sent < TOTAL_NUM; k++) begin
                if (sent < DIRECTED_NUM) begin
                    send_value(8'(directed_values[sent]));
                end else begin
                    send_value(8'($urandom_range(0, 255)));
                end
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (4 * FRAME_BITS) @(posedge i_clk);
        $display("Covered %0d values: %0d digit and sign edge cases, then %0d random bytes.",
                 TOTAL_NUM, DIRECTED_NUM, RANDOM_NUM);
        $display("Compared %0d serial words under bursty input and receiver stalls; %0d failures.",
                 words_checked, fail_count);
        if (fail_count == 0 && pending_words == 0) begin
            $display("signed_three_digit_segment_serializer regression: pass");
        end else begin
            $display("signed_three_digit_segment_serializer regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/stdss_pkg.sv
design/signed_three_digit_segment_serializer.sv
sim/stdss_frame_check.sv
sim/tb_signed_three_digit_segment_serializer.sv
